// File: rtl/rms_db_level_meter_macros.svh
// ----------------------------------------------------------------------------
// RMS dBFS level meter assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RMS_DB_LEVEL_METER_MACROS_SVH
`define RMS_DB_LEVEL_METER_MACROS_SVH

`define RDLM_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("rdlm: forbidden condition seen");

`define RDLM_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rdlm: implication violated");

`endif

// File: rtl/rdlm_pkg.sv
// ----------------------------------------------------------------------------
// RMS dBFS level meter package
// Shared constants, the back-end state type and the queue status struct.
// ----------------------------------------------------------------------------
package rdlm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 16;
    localparam int FLOOR_W     = 7;
    localparam int FRAC_BITS   = 20;
    localparam int MANT_W      = 31;
    localparam int SQ_W        = 31;
    localparam int FS_LOG2     = 30;
    localparam int K_W         = 30;

    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 7'd60;
    localparam logic [K_W-1:0]     DB_PER_LOG2 = 30'd808071242;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_FRAC,
        S_SUB,
        S_MUL,
        S_DIV,
        S_DONE
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: rtl/rdlm_front.sv
// ----------------------------------------------------------------------------
// RMS dBFS level meter front end
// Squares each sample, accumulates the chunk and hands finished chunks on.
// ----------------------------------------------------------------------------
module rdlm_front import rdlm_pkg::*; #(
    parameter int MAX_CHUNK = 4096,
    parameter int CW        = 13,
    parameter int SW        = 43
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_last,
    input  logic                i_q_full,
    output logic                o_q_push,
    output logic [SW-1:0]       o_q_sum,
    output logic [CW-1:0]       o_q_cnt
);

    logic            r_a_valid;
    logic            r_a_last;
    logic [SQ_W-1:0] r_a_sq;
    logic [SW-1:0]   r_sum;
    logic [CW-1:0]   r_cnt;

    logic [SAMPLE_W-1:0]   mag;
    logic [2*SAMPLE_W-1:0] sq_full;
    logic                  adv;
    logic                  take;
    logic [SW-1:0]         n_sum;
    logic [CW-1:0]         n_cnt;

    assign mag     = i_sample[SAMPLE_W-1] ? SAMPLE_W'(-i_sample) : i_sample;
    assign sq_full = mag * mag;
    assign adv     = r_a_valid && !(r_a_last && i_q_full);
    assign o_full  = r_a_valid && !adv;
    assign take    = ({1'b0, r_cnt} < (CW+1)'(MAX_CHUNK));
    assign n_sum   = take ? (r_sum + SW'(r_a_sq)) : r_sum;
    assign n_cnt   = take ? (r_cnt + CW'(1)) : r_cnt;

    assign o_q_push = adv && r_a_last;
    assign o_q_sum  = n_sum;
    assign o_q_cnt  = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_sum     <= '0;
            r_cnt     <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_a_valid <= 1'b1;
            end else if (adv) begin
                r_a_valid <= 1'b0;
            end
            if (adv) begin
                if (r_a_last) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_a_last <= i_last;
            r_a_sq   <= sq_full[SQ_W-1:0];
        end
    end

endmodule

// File: rtl/rdlm_queue.sv
// ----------------------------------------------------------------------------
// RMS dBFS level meter chunk queue
// Two-entry queue of finished chunk totals between front and back ends.
// ----------------------------------------------------------------------------
module rdlm_queue import rdlm_pkg::*; #(
    parameter int W = 56
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_q_stat      o_stat
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_count;

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: rtl/rdlm_back.sv
// ----------------------------------------------------------------------------
// RMS dBFS level meter back end
// Per-chunk log2, dB scaling and floor division, holding one result beat.
// ----------------------------------------------------------------------------
module rdlm_back import rdlm_pkg::*; #(
    parameter int CW = 13,
    parameter int SW = 43
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_q_stat            i_q_stat,
    input  logic [SW-1:0]      i_q_sum,
    input  logic [CW-1:0]      i_q_cnt,
    output logic               o_q_pop,
    input  logic [FLOOR_W-1:0] i_floor,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [LEVEL_W-1:0] o_level
);

    localparam int EW  = $clog2(SW);
    localparam int LW  = EW + FRAC_BITS;
    localparam int PW  = LW + K_W;
    localparam int DLW = PW - 32;
    localparam int DW  = DLW + LEVEL_W;
    localparam int IW  = $clog2(DW + 1);

    t_back_state r_state, n_state;

    logic [SW-1:0]        r_sum, n_sum;
    logic [SW-1:0]        r_v, n_v;
    logic [EW-1:0]        r_e, n_e;
    logic [MANT_W-1:0]    r_m, n_m;
    logic [FRAC_BITS-1:0] r_f, n_f;
    logic [IW-1:0]        r_i, n_i;
    logic                 r_pass, n_pass;
    logic                 r_silent, n_silent;
    logic [LW-1:0]        r_lcnt, n_lcnt;
    logic [LW-1:0]        r_lsum, n_lsum;
    logic [LW-1:0]        r_a, n_a;
    logic [DW-1:0]        r_q, n_q;
    logic [FLOOR_W-1:0]   r_rem, n_rem;
    logic                 r_out_valid, n_out_valid;
    logic [LEVEL_W-1:0]   r_level, n_level;

    logic [2*MANT_W-1:0]  msq;
    logic [MANT_W:0]      sq;
    logic                 fbit;
    logic [LW-1:0]        lval;
    logic [LW-1:0]        num;
    logic [PW-1:0]        dprod;
    logic [FLOOR_W-1:0]   f_eff;
    logic [FLOOR_W:0]     trial;
    logic                 qbit;

    assign msq   = r_m * r_m;
    assign sq    = msq[2*MANT_W-1:MANT_W-1];
    assign fbit  = sq[MANT_W];
    assign lval  = {r_e, r_f[FRAC_BITS-2:0], fbit};
    assign num   = (LW'(FS_LOG2) << FRAC_BITS) + r_lcnt;
    assign dprod = PW'(r_a) * PW'(DB_PER_LOG2);
    assign f_eff = (i_floor == '0) ? FLOOR_W'(1) : i_floor;
    assign trial = {r_rem, r_q[DW-1]};
    assign qbit  = (trial >= {1'b0, f_eff});

    assign o_empty = !r_out_valid;
    assign o_level = r_level;

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_v         = r_v;
        n_e         = r_e;
        n_m         = r_m;
        n_f         = r_f;
        n_i         = r_i;
        n_pass      = r_pass;
        n_silent    = r_silent;
        n_lcnt      = r_lcnt;
        n_lsum      = r_lsum;
        n_a         = r_a;
        n_q         = r_q;
        n_rem       = r_rem;
        n_level     = r_level;
        n_out_valid = r_out_valid && !i_pop;
        o_q_pop     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_q_pop  = 1'b1;
                    n_sum    = i_q_sum;
                    n_v      = SW'(i_q_cnt);
                    n_e      = EW'(SW - 1);
                    n_pass   = 1'b0;
                    n_silent = (i_q_sum == '0);
                    n_state  = (i_q_sum == '0) ? S_DONE : S_NORM;
                end
            end
            S_NORM: begin
                if (r_v[SW-1]) begin
                    n_m     = r_v[SW-1 -: MANT_W];
                    n_f     = '0;
                    n_i     = '0;
                    n_state = S_FRAC;
                end else begin
                    n_v = {r_v[SW-2:0], 1'b0};
                    n_e = r_e - EW'(1);
                end
            end
            S_FRAC: begin
                n_m = fbit ? sq[MANT_W:1] : sq[MANT_W-1:0];
                n_f = {r_f[FRAC_BITS-2:0], fbit};
                n_i = r_i + IW'(1);
                if (r_i == IW'(FRAC_BITS - 1)) begin
                    if (!r_pass) begin
                        n_lcnt  = lval;
                        n_v     = r_sum;
                        n_e     = EW'(SW - 1);
                        n_pass  = 1'b1;
                        n_state = S_NORM;
                    end else begin
                        n_lsum  = lval;
                        n_state = S_SUB;
                    end
                end
            end
            S_SUB: begin
                n_a     = (num > r_lsum) ? (num - r_lsum) : '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_q     = {dprod[PW-1:32], LEVEL_W'(0)};
                n_rem   = '0;
                n_i     = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = qbit ? FLOOR_W'(trial - {1'b0, f_eff}) : trial[FLOOR_W-1:0];
                n_q   = {r_q[DW-2:0], qbit};
                n_i   = r_i + IW'(1);
                if (r_i == IW'(DW - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid = 1'b1;
                    if (r_silent || (|r_q[DW-1:LEVEL_W])) begin
                        n_level = '0;
                    end else if (r_q[LEVEL_W-1:0] == '0) begin
                        n_level = '1;
                    end else begin
                        n_level = LEVEL_W'((LEVEL_W+1)'(1) << LEVEL_W) -
                                  r_q[LEVEL_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_v      <= n_v;
        r_e      <= n_e;
        r_m      <= n_m;
        r_f      <= n_f;
        r_i      <= n_i;
        r_pass   <= n_pass;
        r_silent <= n_silent;
        r_lcnt   <= n_lcnt;
        r_lsum   <= n_lsum;
        r_a      <= n_a;
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_level  <= n_level;
    end

endmodule

// File: rtl/rms_db_level_meter.sv
// ----------------------------------------------------------------------------
// RMS dBFS level meter
// Chunk loudness of 16-bit PCM as unsigned Q0.16 over a programmable floor.
// ----------------------------------------------------------------------------
// The meter takes one sample per clock for as long as the chunk queue has
// room. After its last sample, a chunk's level reaches the result side once
// the back end has normalized the count and the sum, each by shifts at most
// one less than the accumulator width, and run the bit-serial floor division,
// whose quotient width D is 40 bits at the default chunk size. A silent
// chunk skips the log and division work. The back end handles one chunk at
// a time while two finished chunks wait in the queue and one more in the
// front stage, so chunks shorter than the back-end time stall the input.
module rms_db_level_meter import rdlm_pkg::*; #(
    parameter int MAX_CHUNK = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_last,
    output logic                empty,
    input  logic                pop,
    output logic [LEVEL_W-1:0]  o_level,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [FLOOR_W-1:0]  i_cfg_data
);

`include "rms_db_level_meter_macros.svh"

    localparam int CW = $clog2(MAX_CHUNK + 1);
    localparam int SW = FS_LOG2 + CW;

    logic [FLOOR_W-1:0] r_floor;
    logic               q_push;
    logic               q_pop;
    logic [SW-1:0]      f_sum;
    logic [CW-1:0]      f_cnt;
    logic [SW+CW-1:0]   q_out;
    t_q_stat            q_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= FLOOR_RESET;
        end else if (i_cfg_valid) begin
            r_floor <= i_cfg_data;
        end
    end

    rdlm_front #(.MAX_CHUNK(MAX_CHUNK), .CW(CW), .SW(SW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_sample (i_sample),
        .i_last   (i_last),
        .i_q_full (q_stat.full),
        .o_q_push (q_push),
        .o_q_sum  (f_sum),
        .o_q_cnt  (f_cnt)
    );

    rdlm_queue #(.W(SW + CW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_sum, f_cnt}),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    rdlm_back #(.CW(CW), .SW(SW)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_q_sum  (q_out[SW+CW-1:CW]),
        .i_q_cnt  (q_out[CW-1:0]),
        .o_q_pop  (q_pop),
        .i_floor  (r_floor),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_level  (o_level)
    );

    `RDLM_ASSERT_NEVER(a_no_push_when_full, q_push && q_stat.full)
    `RDLM_ASSERT_IMPLY(a_pop_only_when_ready, q_pop, !q_stat.empty)

endmodule
